>>> rtl/core/saf_pkg.sv
package saf_pkg;

  localparam int FIFO_DEPTH  = 1024;
  localparam int MAX_READ    = 64;
  localparam int SAMPLE_BITS = 24;
  localparam int STAT_W      = 32;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W     = PTR_W + 1;
  localparam int COUNT_W     = 7;
  localparam int CLIP_W      = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int FULL_SCALE  = 2 ** (SAMPLE_BITS - 2);

  localparam logic signed [SAMPLE_BITS-1:0] POS_FULL = SAMPLE_BITS'(FULL_SCALE);
  localparam logic signed [SAMPLE_BITS-1:0] NEG_FULL = SAMPLE_BITS'(-FULL_SCALE);

  typedef enum logic [1:0] {
    REQ_STEREO = 2'd0,
    REQ_MONO   = 2'd1,
    REQ_READ   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } back_state_t;

  // classified request as it waits in the command queue
  typedef struct packed {
    req_t                          kind;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [CLIP_W-1:0]             clip_inc;
    logic [COUNT_W-1:0]            count;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          frame_valid;
    logic                          last;
    logic                          write_accepted;
    logic [LEVEL_W-1:0]            buffered;
    logic [STAT_W-1:0]             read_total;
    logic [STAT_W-1:0]             requested_total;
    logic [STAT_W-1:0]             underrun_total;
    logic [STAT_W-1:0]             clipped_total;
  } res_t;

endpackage

>>> rtl/core/saf_ram.sv
module saf_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/saf_front.sv
module saf_front (
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             req_type,
  input  logic signed [saf_pkg::SAMPLE_BITS-1:0] req_left,
  input  logic signed [saf_pkg::SAMPLE_BITS-1:0] req_right,
  input  logic [saf_pkg::COUNT_W-1:0]            read_count,
  input  logic                                   q_full,
  output logic                                   push,
  output saf_pkg::cmd_t                          cmd
);

  import saf_pkg::*;

  function automatic logic clips(input logic signed [SAMPLE_BITS-1:0] s);
    return (s > POS_FULL) || (s < NEG_FULL);
  endfunction

  logic signed [SAMPLE_BITS:0]   sum;
  logic signed [SAMPLE_BITS-1:0] mono;
  logic                          clip_l;
  logic                          clip_r;
  logic                          clip_m;

  // halving by dropping the low bit rounds toward minus infinity
  assign sum    = {req_left[SAMPLE_BITS-1], req_left}
                + {req_right[SAMPLE_BITS-1], req_right};
  assign mono   = sum[SAMPLE_BITS:1];
  assign clip_l = clips(req_left);
  assign clip_r = clips(req_right);
  assign clip_m = clips(mono);

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    cmd.kind     = req_t'(req_type);
    cmd.left     = req_left;
    cmd.right    = req_right;
    cmd.clip_inc = '0;
    cmd.count    = (read_count > COUNT_W'(MAX_READ)) ? COUNT_W'(MAX_READ) : read_count;
    unique case (req_t'(req_type))
      REQ_STEREO: begin
        cmd.clip_inc = CLIP_W'(clip_l) + CLIP_W'(clip_r);
      end
      REQ_MONO: begin
        cmd.left     = mono;
        cmd.right    = mono;
        cmd.clip_inc = clip_m ? CLIP_W'(2) : '0;
      end
      default: begin
        cmd.clip_inc = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/saf_queue.sv
module saf_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  saf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output saf_pkg::cmd_t pop_cmd
);

  import saf_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/saf_back.sv
module saf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [saf_pkg::LEVEL_W-1:0]   cfg_data,
  input  logic                          q_valid,
  input  saf_pkg::cmd_t                 q_cmd,
  output logic                          q_pop,
  input  logic                          out_ready,
  output logic                          out_valid,
  output saf_pkg::res_t                 out_res
);

  import saf_pkg::*;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p,
                                               input logic [LEVEL_W-1:0] lim);
    logic [LEVEL_W-1:0] inc;
    inc = LEVEL_W'(p) + 1'b1;
    return (inc >= lim) ? '0 : inc[PTR_W-1:0];
  endfunction

  back_state_t        state;
  back_state_t        state_next;
  logic [LEVEL_W-1:0] capacity;
  logic [LEVEL_W-1:0] cap_eff;
  logic [PTR_W-1:0]   head;
  logic [PTR_W-1:0]   head_next;
  logic [PTR_W-1:0]   tail;
  logic [PTR_W-1:0]   tail_next;
  logic [LEVEL_W-1:0] fill;
  logic [LEVEL_W-1:0] fill_next;
  logic [STAT_W-1:0]  delivered;
  logic [STAT_W-1:0]  delivered_next;
  logic [STAT_W-1:0]  requested;
  logic [STAT_W-1:0]  requested_next;
  logic [STAT_W-1:0]  underruns;
  logic [STAT_W-1:0]  underruns_next;
  logic [STAT_W-1:0]  clipped;
  logic [STAT_W-1:0]  clipped_next;
  logic [COUNT_W-1:0] remain;
  logic [COUNT_W-1:0] remain_next;
  logic [COUNT_W-1:0] n_frames;
  logic               out_free;
  logic               pop;
  logic               emit;
  logic               accepted;
  logic               out_load;
  res_t               res_next;
  logic               ram_we;
  logic               ram_re;
  logic [2*SAMPLE_BITS-1:0] ram_rdata;

  assign cap_eff  = (capacity == '0) ? LEVEL_W'(1)
                  : (capacity > LEVEL_W'(FIFO_DEPTH)) ? LEVEL_W'(FIFO_DEPTH) : capacity;
  assign out_free = !out_valid || out_ready;
  assign pop      = (state == ST_IDLE) && q_valid && out_free;
  assign q_pop    = pop;
  assign n_frames = (fill > LEVEL_W'(q_cmd.count)) ? q_cmd.count : fill[COUNT_W-1:0];

  saf_ram #(
    .WIDTH (2 * SAMPLE_BITS),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head),
    .wdata ({q_cmd.left, q_cmd.right}),
    .re    (ram_re),
    .raddr (tail),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (pop && q_cmd.kind == REQ_READ && q_cmd.count != '0 && fill != '0) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (out_free && remain == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    fill_next      = fill;
    delivered_next = delivered;
    requested_next = requested;
    underruns_next = underruns;
    clipped_next   = clipped;
    remain_next    = remain;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    emit           = 1'b0;
    accepted       = 1'b0;
    out_load       = 1'b0;
    res_next       = out_res;

    unique case (state)
      ST_IDLE: begin
        if (pop) begin
          unique case (q_cmd.kind) inside
            REQ_STEREO, REQ_MONO: begin
              emit = 1'b1;
              if (fill < cap_eff) begin
                ram_we       = 1'b1;
                accepted     = 1'b1;
                head_next    = advance(head, cap_eff);
                fill_next    = fill + 1'b1;
                clipped_next = clipped + STAT_W'(q_cmd.clip_inc);
              end
            end
            REQ_CLEAR: begin
              emit           = 1'b1;
              tail_next      = head;
              fill_next      = '0;
              delivered_next = '0;
              requested_next = '0;
              underruns_next = '0;
              clipped_next   = '0;
            end
            default: begin
              if (q_cmd.count == '0) begin
                emit = 1'b1;
              end else begin
                requested_next = requested + STAT_W'(q_cmd.count);
                if (n_frames < q_cmd.count) begin
                  underruns_next = underruns + 1'b1;
                end
                if (n_frames == '0) begin
                  emit = 1'b1;
                end else begin
                  // first frame read issued here; ST_READ loads it from the RAM read register
                  ram_re         = 1'b1;
                  tail_next      = advance(tail, cap_eff);
                  fill_next      = fill - 1'b1;
                  delivered_next = delivered + 1'b1;
                  remain_next    = n_frames - 1'b1;
                end
              end
            end
          endcase
        end
        if (emit) begin
          out_load                 = 1'b1;
          res_next.left            = '0;
          res_next.right           = '0;
          res_next.frame_valid     = 1'b0;
          res_next.last            = 1'b1;
          res_next.write_accepted  = accepted;
          res_next.buffered        = fill_next;
          res_next.read_total      = delivered_next;
          res_next.requested_total = requested_next;
          res_next.underrun_total  = underruns_next;
          res_next.clipped_total   = clipped_next;
        end
      end
      ST_READ: begin
        if (out_free) begin
          // stats already reflect this frame; the next read overlaps the load
          out_load                 = 1'b1;
          res_next.left            = ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
          res_next.right           = ram_rdata[SAMPLE_BITS-1:0];
          res_next.frame_valid     = 1'b1;
          res_next.last            = (remain == '0);
          res_next.write_accepted  = 1'b0;
          res_next.buffered        = fill;
          res_next.read_total      = delivered;
          res_next.requested_total = requested;
          res_next.underrun_total  = underruns;
          res_next.clipped_total   = clipped;
          if (remain != '0) begin
            ram_re         = 1'b1;
            tail_next      = advance(tail, cap_eff);
            fill_next      = fill - 1'b1;
            delivered_next = delivered + 1'b1;
            remain_next    = remain - 1'b1;
          end
        end
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      capacity  <= LEVEL_W'(FIFO_DEPTH);
      head      <= '0;
      tail      <= '0;
      fill      <= '0;
      delivered <= '0;
      requested <= '0;
      underruns <= '0;
      clipped   <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      delivered <= delivered_next;
      requested <= requested_next;
      underruns <= underruns_next;
      clipped   <= clipped_next;
      remain    <= remain_next;
      if (cfg_we) begin
        capacity <= cfg_data;
        head     <= '0;
        tail     <= '0;
        fill     <= '0;
      end else begin
        head <= head_next;
        tail <= tail_next;
        fill <= fill_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= res_next;
    end
  end

endmodule

>>> rtl/core/stereo_audio_fifo_with_stats.sv
// Channel   Handshake             Payload
// input     in_valid / in_ready   req_type, req_left, req_right, read_count
// result    out_valid / out_ready out_left ... clipped_total
// config    cfg_valid / cfg_ready cfg_data (capacity)
//
// Writes, clears, zero-count and empty reads each give a single result from the back end.
// A read of n frames gives n results, each fetched through the registered RAM read port.
// A four-entry command queue lets the input side keep taking requests meanwhile.
// Reset is synchronous; sample storage is undefined until written, no clearing pass.
// A stalled result holds the back end; once the queue fills, in_ready drops.
module stereo_audio_fifo_with_stats (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [saf_pkg::LEVEL_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             req_type,
  input  logic signed [saf_pkg::SAMPLE_BITS-1:0] req_left,
  input  logic signed [saf_pkg::SAMPLE_BITS-1:0] req_right,
  input  logic [saf_pkg::COUNT_W-1:0]            read_count,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [saf_pkg::SAMPLE_BITS-1:0] out_left,
  output logic signed [saf_pkg::SAMPLE_BITS-1:0] out_right,
  output logic                                   frame_valid,
  output logic                                   last_result,
  output logic                                   write_accepted,
  output logic [saf_pkg::LEVEL_W-1:0]            buffered_frames,
  output logic [saf_pkg::STAT_W-1:0]             frames_read_total,
  output logic [saf_pkg::STAT_W-1:0]             frames_requested_total,
  output logic [saf_pkg::STAT_W-1:0]             underrun_total,
  output logic [saf_pkg::STAT_W-1:0]             clipped_total
);

  import saf_pkg::*;

  cmd_t push_cmd;
  cmd_t pop_cmd;
  res_t res;
  logic push;
  logic pop;
  logic q_full;
  logic q_valid;

  assign cfg_ready = 1'b1;

  saf_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .req_type   (req_type),
    .req_left   (req_left),
    .req_right  (req_right),
    .read_count (read_count),
    .q_full     (q_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  saf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_cmd   (pop_cmd)
  );

  saf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_cmd     (pop_cmd),
    .q_pop     (pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_left               = res.left;
  assign out_right              = res.right;
  assign frame_valid            = res.frame_valid;
  assign last_result            = res.last;
  assign write_accepted         = res.write_accepted;
  assign buffered_frames        = res.buffered;
  assign frames_read_total      = res.read_total;
  assign frames_requested_total = res.requested_total;
  assign underrun_total         = res.underrun_total;
  assign clipped_total          = res.clipped_total;

endmodule

>>> rtl/core/saf_checker.sv
module saf_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [saf_pkg::SAMPLE_BITS-1:0] out_left,
  input logic signed [saf_pkg::SAMPLE_BITS-1:0] out_right,
  input logic                                   frame_valid,
  input logic                                   last_result,
  input logic                                   write_accepted,
  input logic [saf_pkg::LEVEL_W-1:0]            buffered_frames
);

  import saf_pkg::*;

  // a result not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // results without a frame end their request and carry zero samples
  a_no_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_valid |-> last_result && out_left == '0 && out_right == '0)
    else $error("frameless result not last or not zero");

  // a stored write leaves at least one frame buffered
  a_write_fill: assert property (@(posedge clk) disable iff (rst)
    out_valid && write_accepted |-> !frame_valid && buffered_frames != '0)
    else $error("accepted write with empty buffer");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> buffered_frames <= LEVEL_W'(FIFO_DEPTH))
    else $error("buffered frames beyond depth");

  // a frame transfer not marked last is followed by more frames of the same read
  a_frame_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && frame_valid && !last_result
      |=> !out_valid || frame_valid)
    else $error("read run broken before last frame");

endmodule

bind stereo_audio_fifo_with_stats saf_checker u_saf_checker (.*);

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import saf_pkg::*;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [COUNT_W-1:0]            count_t;
  typedef logic [LEVEL_W-1:0]            level_t;

  // one directed row: a capacity write (value in cnt) or a request,
  // optionally with the result typed in by hand
  typedef struct {
    bit    cfg;
    req_t  kind;
    int    l;
    int    r;
    int    cnt;
    bit    pin;
    bit    acc;
    int    lvl;
    int    clip;
    int    und;
  } row_t;

  localparam int FS          = FULL_SCALE;
  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SEG_ITEMS   = 58;

  logic    clk;
  logic    rst       = 1'b1;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  level_t  cfg_data  = '0;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  logic [1:0] req_type = '0;
  sample_t req_left   = '0;
  sample_t req_right  = '0;
  count_t  read_count = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t out_left;
  sample_t out_right;
  logic    frame_valid;
  logic    last_result;
  logic    write_accepted;
  level_t  buffered_frames;
  logic [STAT_W-1:0] frames_read_total;
  logic [STAT_W-1:0] frames_requested_total;
  logic [STAT_W-1:0] underrun_total;
  logic [STAT_W-1:0] clipped_total;

  stereo_audio_fifo_with_stats u_dut (
    .clk                    (clk),
    .rst                    (rst),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_data               (cfg_data),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .req_type               (req_type),
    .req_left               (req_left),
    .req_right              (req_right),
    .read_count             (read_count),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_left               (out_left),
    .out_right              (out_right),
    .frame_valid            (frame_valid),
    .last_result            (last_result),
    .write_accepted         (write_accepted),
    .buffered_frames        (buffered_frames),
    .frames_read_total      (frames_read_total),
    .frames_requested_total (frames_requested_total),
    .underrun_total         (underrun_total),
    .clipped_total          (clipped_total)
  );

  row_t dir_rows [24] = '{
    '{1'b0, REQ_READ,   0,        0,        1,   1'b1, 1'b0, 0,  0,  1},
    '{1'b0, REQ_READ,   0,        0,        0,   1'b1, 1'b0, 0,  0,  1},
    '{1'b0, REQ_STEREO, FS,       -FS,      0,   1'b1, 1'b1, 1,  0,  1},
    '{1'b0, REQ_STEREO, FS + 1,   -FS - 1,  0,   1'b1, 1'b1, 2,  2,  1},
    '{1'b0, REQ_STEREO, 8388607,  -8388608, 0,   1'b1, 1'b1, 3,  4,  1},
    '{1'b0, REQ_MONO,   8388607,  8388607,  0,   1'b1, 1'b1, 4,  6,  1},
    '{1'b0, REQ_MONO,   -8388608, -8388608, 0,   1'b1, 1'b1, 5,  8,  1},
    '{1'b0, REQ_MONO,   -1,       0,        0,   1'b0, 1'b0, 0,  0,  0},
    '{1'b0, REQ_MONO,   3,        0,        0,   1'b0, 1'b0, 0,  0,  0},
    '{1'b0, REQ_MONO,   FS,       FS + 2,   0,   1'b1, 1'b1, 8,  10, 1},
    '{1'b0, REQ_MONO,   -FS,      -FS - 1,  0,   1'b1, 1'b1, 9,  12, 1},
    '{1'b0, REQ_STEREO, 0,        0,        0,   1'b1, 1'b1, 10, 12, 1},
    '{1'b0, REQ_READ,   0,        0,        3,   1'b0, 1'b0, 0,  0,  0},
    '{1'b0, REQ_READ,   0,        0,        127, 1'b0, 1'b0, 0,  0,  0},
    '{1'b0, REQ_STEREO, 5592405,  -5592406, 0,   1'b0, 1'b0, 0,  0,  0},
    '{1'b0, REQ_READ,   0,        0,        64,  1'b0, 1'b0, 0,  0,  0},
    '{1'b0, REQ_CLEAR,  0,        0,        0,   1'b1, 1'b0, 0,  0,  0},
    '{1'b0, REQ_READ,   0,        0,        65,  1'b1, 1'b0, 0,  0,  1},
    '{1'b1, REQ_STEREO, 0,        0,        0,   1'b0, 1'b0, 0,  0,  0},
    '{1'b0, REQ_STEREO, 100,      -100,     0,   1'b1, 1'b1, 1,  0,  1},
    '{1'b0, REQ_STEREO, FS + 5,   -FS - 5,  0,   1'b1, 1'b0, 1,  0,  1},
    '{1'b0, REQ_MONO,   1,        1,        0,   1'b1, 1'b0, 1,  0,  1},
    '{1'b0, REQ_READ,   0,        0,        2,   1'b0, 1'b0, 0,  0,  0},
    '{1'b1, REQ_STEREO, 0,        0,        2047, 1'b0, 1'b0, 0, 0,  0}
  };

  level_t seg_cap [6] = '{level_t'(3), level_t'(1024), level_t'(1), level_t'(2047),
                          level_t'(4), level_t'(6)};

  // FIFO mirror
  level_t  cap_reg;
  sample_t left_mem  [FIFO_DEPTH];
  sample_t right_mem [FIFO_DEPTH];
  int      wr_ptr;
  int      rd_ptr;
  int      fill;
  logic [STAT_W-1:0] delivered;
  logic [STAT_W-1:0] requested;
  logic [STAT_W-1:0] underruns;
  logic [STAT_W-1:0] clips;

  res_t    frames_due [$];
  int      mismatches   = 0;
  int      quiet_cycles = 0;
  int      last_idx;
  int      send_idle_pct = 10;
  int      recv_idle_pct = 80;
  bit      hold_go = 1'b0;

  bit          pin_now = 1'b0;
  bit          pin_acc = 1'b0;
  level_t      pin_lvl = '0;
  logic [31:0] pin_clip = '0;
  logic [31:0] pin_und  = '0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int usable_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > FIFO_DEPTH) return FIFO_DEPTH;
    return int'(cap_reg);
  endfunction

  function automatic int over_range(sample_t s);
    return (s > POS_FULL || s < NEG_FULL) ? 1 : 0;
  endfunction

  function automatic int bump(int p);
    return (p + 1 >= usable_cap()) ? 0 : p + 1;
  endfunction

  task automatic stamp_frame(sample_t l, sample_t r, bit fv, bit last, bit acc);
    res_t f;
    f.left            = l;
    f.right           = r;
    f.frame_valid     = fv;
    f.last            = last;
    f.write_accepted  = acc;
    f.buffered        = level_t'(fill);
    f.read_total      = delivered;
    f.requested_total = requested;
    f.underrun_total  = underruns;
    f.clipped_total   = clips;
    frames_due.push_back(f);
  endtask

  task automatic apply_request(req_t kind, sample_t l, sample_t r, count_t cnt);
    logic signed [SAMPLE_BITS:0] sum;
    int want;
    int take;
    int slot;
    bit acc;
    acc = 1'b0;
    case (kind)
      REQ_STEREO, REQ_MONO: begin
        if (fill < usable_cap()) begin
          if (kind == REQ_STEREO) begin
            clips += over_range(l) + over_range(r);
          end else begin
            // downmix floors toward minus infinity
            sum = l + r;
            l = sample_t'(sum >>> 1);
            r = l;
            clips += 2 * over_range(l);
          end
          left_mem[wr_ptr]  = l;
          right_mem[wr_ptr] = r;
          wr_ptr = bump(wr_ptr);
          fill++;
          acc = 1'b1;
        end
        stamp_frame('0, '0, 1'b0, 1'b1, acc);
      end
      REQ_CLEAR: begin
        rd_ptr    = wr_ptr;
        fill      = 0;
        delivered = '0;
        requested = '0;
        underruns = '0;
        clips     = '0;
        stamp_frame('0, '0, 1'b0, 1'b1, 1'b0);
      end
      default: begin
        if (cnt == 0) begin
          stamp_frame('0, '0, 1'b0, 1'b1, 1'b0);
        end else begin
          want = (cnt > MAX_READ) ? MAX_READ : int'(cnt);
          take = (want < fill) ? want : fill;
          requested += want;
          if (take < want) underruns++;
          if (take == 0) begin
            stamp_frame('0, '0, 1'b0, 1'b1, 1'b0);
          end else begin
            for (int k = 0; k < take; k++) begin
              slot   = rd_ptr;
              rd_ptr = bump(rd_ptr);
              fill--;
              delivered++;
              stamp_frame(left_mem[slot], right_mem[slot], 1'b1, k == take - 1, 1'b0);
            end
          end
        end
      end
    endcase
  endtask

  task automatic check_frame();
    res_t want;
    res_t got;
    got = '{out_left, out_right, frame_valid, last_result, write_accepted, buffered_frames,
            frames_read_total, frames_requested_total, underrun_total, clipped_total};
    if (frames_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing pending: L=%0d R=%0d fv=%0b last=%0b", $realtime,
                 got.left, got.right, got.frame_valid, got.last);
    end else begin
      want = frames_due.pop_front();
      if (want.left != got.left || want.right != got.right ||
          want.frame_valid != got.frame_valid || want.last != got.last ||
          want.write_accepted != got.write_accepted || want.buffered != got.buffered ||
          want.read_total != got.read_total || want.requested_total != got.requested_total ||
          want.underrun_total != got.underrun_total ||
          want.clipped_total != got.clipped_total) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch", $realtime);
          $display("  exp L=%0d R=%0d fv=%0b last=%0b acc=%0b lvl=%0d rd=%0d rq=%0d un=%0d cl=%0d",
                   want.left, want.right, want.frame_valid, want.last, want.write_accepted,
                   want.buffered, want.read_total, want.requested_total,
                   want.underrun_total, want.clipped_total);
          $display("  got L=%0d R=%0d fv=%0b last=%0b acc=%0b lvl=%0d rd=%0d rq=%0d un=%0d cl=%0d",
                   got.left, got.right, got.frame_valid, got.last, got.write_accepted,
                   got.buffered, got.read_total, got.requested_total,
                   got.underrun_total, got.clipped_total);
        end
      end
    end
  endtask

  // scoreboard: config, then request, then result, all on the same edge
  always @(posedge clk) begin
    if (rst) begin
      cap_reg   = level_t'(FIFO_DEPTH);
      wr_ptr    = 0;
      rd_ptr    = 0;
      fill      = 0;
      delivered = '0;
      requested = '0;
      underruns = '0;
      clips     = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_reg = cfg_data;
        wr_ptr  = 0;
        rd_ptr  = 0;
        fill    = 0;
      end
      if (in_valid && in_ready) begin
        apply_request(req_t'(req_type), req_left, req_right, read_count);
        if (pin_now) begin
          last_idx = frames_due.size() - 1;
          frames_due[last_idx].write_accepted = pin_acc;
          frames_due[last_idx].buffered       = pin_lvl;
          frames_due[last_idx].clipped_total  = pin_clip;
          frames_due[last_idx].underrun_total = pin_und;
        end
      end
      if (out_valid && out_ready) check_frame();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results pending", $realtime,
                 quiet_cycles, frames_due.size());
        $display("stereo_audio_fifo_with_stats regression: fail");
        $finish;
      end
    end
  end

  // result side; a long hold-off backs up the command queue
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic sample_t pick_sample();
    case ($urandom_range(3))
      0: return sample_t'($urandom);
      1: return sample_t'(FS + int'($urandom_range(4)) - 2);
      2: return sample_t'(-FS + int'($urandom_range(4)) - 2);
      default: return sample_t'(int'($urandom_range(2000)) - 1000);
    endcase
  endfunction

  function automatic req_t pick_kind();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return REQ_STEREO;
    if (roll < 60) return REQ_MONO;
    if (roll < 97) return REQ_READ;
    return REQ_CLEAR;
  endfunction

  function automatic count_t pick_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return count_t'($urandom_range(1, 8));
    if (roll < 85) return count_t'($urandom_range(9, 64));
    if (roll < 93) return count_t'($urandom_range(65, 127));
    return '0;
  endfunction

  // caller sits on a rising edge; valid is only lowered when a gap is taken
  task automatic send_req(req_t kind, sample_t l, sample_t r, count_t cnt,
                          bit pin, bit acc, int lvl, int clip, int und);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    req_left     <= l;
    req_right    <= r;
    read_count   <= cnt;
    pin_now      <= pin;
    pin_acc      <= acc;
    pin_lvl      <= level_t'(lvl);
    pin_clip     <= clip;
    pin_und      <= und;
    do @(posedge clk); while (!in_ready);
  endtask

  // step past the current edge first so the scoreboard has booked the last transfer
  task automatic drain(int settle);
    @(posedge clk);
    while (frames_due.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_capacity(level_t v);
    in_valid <= 1'b0;
    drain(4);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    row_t row;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.cfg)
        write_capacity(level_t'(row.cnt));
      else
        send_req(row.kind, sample_t'(row.l), sample_t'(row.r), count_t'(row.cnt),
                 row.pin, row.acc, row.lvl, row.clip, row.und);
    end

    seg_cap[5] = level_t'($urandom_range(2, 9));
    for (int seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct = 80;
        recv_idle_pct = 10;
      end else if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_capacity(seg_cap[seg]);
      if (seg == 4) hold_go = 1'b1;
      repeat (SEG_ITEMS)
        send_req(pick_kind(), pick_sample(), pick_sample(), pick_count(),
                 1'b0, 1'b0, 0, 0, 0);
    end

    in_valid <= 1'b0;
    drain(16);
    if (mismatches == 0) begin
      $display("stereo_audio_fifo_with_stats regression: pass");
    end else begin
      $display("stereo_audio_fifo_with_stats regression: fail");
    end
    $finish;
  end

endmodule
